FILE: sv/segment_address_translator_macros.svh
// Assertion helpers shared by the translator RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef SEGMENT_ADDRESS_TRANSLATOR_MACROS_SVH
`define SEGMENT_ADDRESS_TRANSLATOR_MACROS_SVH

// Same-cycle implication.
`define SAT_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/sat_pkg.sv
package sat_pkg;

    localparam int SAT_SLOTS_DEF = 16;
    localparam int DIV_STEPS     = 32;
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = 1;
    localparam int QCNT_W        = 2;

    localparam int IN_DATA_W  = 136;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    localparam logic [31:0] MAX_SEG_RESET = 32'd64;

    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_WRITE     = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BOUNDS = 2'd1;
    localparam logic [1:0] ST_NOSEG  = 2'd2;

    typedef struct packed {
        logic        is_write;
        logic        slot_ok;
        logic [31:0] logical_address;
        logic [15:0] access_size;
        logic [3:0]  slot_index;
        logic        slot_enable;
        logic [15:0] segment_id;
        logic [31:0] segment_base;
        logic [31:0] segment_length;
    } req_t;

    typedef struct packed {
        logic [15:0] segment_id;
        logic [31:0] base;
        logic [31:0] length;
    } slot_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_WRITE,
        B_DIV,
        B_WALK,
        B_TAIL,
        B_CHECK,
        B_DONE
    } back_state_t;

endpackage

FILE: sv/segment_address_translator.sv
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  request: tuser opcode, tdata slot and address fields
// m_*       out        m_tvalid / m_tready  result: tuser status, tdata physical address
// cfg_*     in         cfg_valid/cfg_ready  max_segment_size write
//
// A translate request runs through the one-bit-per-cycle restoring divider, then walks the
// slot table, one slot per cycle, on its single read port, then adds offset and access size,
// checks bounds and hands off the result. A slot write skips the divider and the table walk.
// Requests are worked one at a time by the back end.
// Reset (rst_n low, asynchronous) clears all slot valid bits and loads max_segment_size
// with 64; slot contents are not cleared. The input side keeps accepting into a two-entry
// queue, until it is full, while the back end is busy or the result register is stalled.
`include "segment_address_translator_macros.svh"

module segment_address_translator #(
    parameter int SEGMENT_SLOTS = sat_pkg::SAT_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] logical_address, [47:32] access_size, [51:48] slot_index,
    // [52] slot_enable, [68:53] segment_id, [100:69] segment_base,
    // [132:101] segment_length, [135:133] zero
    input  logic [sat_pkg::IN_DATA_W-1:0]  s_tdata,
    // [0] opcode
    input  logic [sat_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [32:0] physical_address, [39:33] zero
    output logic [sat_pkg::OUT_DATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [sat_pkg::OUT_USER_W-1:0] m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [31:0]                    cfg_data
);
    import sat_pkg::*;

    logic [31:0] max_segment_size_reg;
    logic [31:0] max_segment_size_next;
    logic        f_push_valid;
    logic        f_push_ready;
    req_t        f_push_data;
    logic        q_pop_valid;
    logic        q_pop_ready;
    req_t        q_pop_data;
    logic [32:0] b_phys;
    logic [1:0]  b_status;

    // Configuration is taken in any cycle; the caller writes only while idle.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        max_segment_size_next = max_segment_size_reg;
        if (cfg_valid && cfg_ready)
        begin
            max_segment_size_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_segment_size_reg <= MAX_SEG_RESET;
        end
        else
        begin
            max_segment_size_reg <= max_segment_size_next;
        end
    end

    // Front end: register and classify each request.
    sat_front #(
        .SEGMENT_SLOTS (SEGMENT_SLOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (f_push_valid),
        .push_ready (f_push_ready),
        .push_data  (f_push_data)
    );

    // Hold decoded requests between the two halves.
    sat_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_push_valid),
        .push_ready (f_push_ready),
        .push_data  (f_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    // Back end: divide, walk the slot table, check bounds, hand over the result; or write a slot.
    sat_back #(
        .SEGMENT_SLOTS (SEGMENT_SLOTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .divisor    (max_segment_size_reg),
        .q_valid    (q_pop_valid),
        .q_ready    (q_pop_ready),
        .q_data     (q_pop_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_phys   (b_phys),
        .out_status (b_status)
    );

    assign m_tdata = {7'd0, b_phys};
    assign m_tuser = b_status;

    // A faulted result never carries an address.
    `SAT_ASSERT_IMPLIES(a_fault_addr_zero, m_tvalid && (m_tuser != ST_OK), m_tdata[32:0] == 33'd0, "fault result with non-zero address")
    // A configuration write lands in the divisor register.
    `SAT_ASSERT_NEXT(a_cfg_load, cfg_valid && cfg_ready, max_segment_size_reg == $past(cfg_data), "max_segment_size not loaded")
    // Input ready drops only right after a request was taken.
    `SAT_ASSERT_IMPLIES(a_ready_fall, $fell(s_tready), $past(s_tvalid && s_tready), "s_tready fell without an accepted request")

endmodule

FILE: sv/sat_queue.sv
module sat_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  sat_pkg::req_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output sat_pkg::req_t pop_data
);
    import sat_pkg::*;

    req_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/sat_front.sv
module sat_front #(
    parameter int SEGMENT_SLOTS = sat_pkg::SAT_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sat_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [sat_pkg::IN_USER_W-1:0] s_tuser,
    output logic                          push_valid,
    input  logic                          push_ready,
    output sat_pkg::req_t                 push_data
);
    import sat_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t req_reg;
    req_t req_dec;

    // Unpack the request and classify it.
    always_comb
    begin
        req_dec.logical_address = s_tdata[31:0];
        req_dec.access_size     = s_tdata[47:32];
        req_dec.slot_index      = s_tdata[51:48];
        req_dec.slot_enable     = s_tdata[52];
        req_dec.segment_id      = s_tdata[68:53];
        req_dec.segment_base    = s_tdata[100:69];
        req_dec.segment_length  = s_tdata[132:101];
        req_dec.is_write        = (s_tuser[0] == OP_WRITE);
        // Drop writes to slots beyond the table later on.
        req_dec.slot_ok         = ({28'd0, s_tdata[51:48]} < 32'(SEGMENT_SLOTS));
    end

    assign s_tready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_data  = req_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_reg <= req_dec;
        end
    end

endmodule

FILE: sv/sat_back.sv
module sat_back #(
    parameter int SEGMENT_SLOTS = sat_pkg::SAT_SLOTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [31:0]   divisor,
    input  logic          q_valid,
    output logic          q_ready,
    input  sat_pkg::req_t q_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [32:0]   out_phys,
    output logic [1:0]    out_status
);
    import sat_pkg::*;

    localparam int IDX_W = (SEGMENT_SLOTS > 1) ? $clog2(SEGMENT_SLOTS) : 1;

    back_state_t        state_reg;
    back_state_t        state_next;
    req_t               item_reg;
    req_t               item_next;
    logic [31:0]        rem_reg;
    logic [31:0]        rem_next;
    logic [31:0]        quo_reg;
    logic [31:0]        quo_next;
    logic [4:0]         bit_cnt_reg;
    logic [4:0]         bit_cnt_next;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [IDX_W-1:0]   rd_idx_next;
    logic               cmp_pend_reg;
    logic               cmp_pend_next;
    logic               found_reg;
    logic               found_next;
    logic [31:0]        hit_base_reg;
    logic [31:0]        hit_base_next;
    logic [31:0]        hit_len_reg;
    logic [31:0]        hit_len_next;
    logic [32:0]        sum_reg;
    logic [32:0]        sum_next;
    logic [32:0]        res_phys_reg;
    logic [32:0]        res_phys_next;
    logic [1:0]         res_status_reg;
    logic [1:0]         res_status_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [32:0]        out_phys_reg;
    logic [32:0]        out_phys_next;
    logic [1:0]         out_status_reg;
    logic [1:0]         out_status_next;

    slot_t                    slot_mem [SEGMENT_SLOTS];
    logic [SEGMENT_SLOTS-1:0] slot_valid_reg;
    slot_t                    rd_slot_reg;
    logic                     rd_valid_reg;

    logic [32:0]      rem_shift;
    logic [33:0]      diff;
    logic             match;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;

    assign rem_shift = {rem_reg, quo_reg[31]};
    assign diff      = {1'b0, rem_shift} - {2'b00, divisor};
    assign match     = cmp_pend_reg && rd_valid_reg && (quo_reg[31:16] == 16'd0)
                       && (rd_slot_reg.segment_id == quo_reg[15:0]);
    assign wr_en     = (state_reg == B_WRITE) && item_reg.slot_ok;
    assign wr_addr   = IDX_W'(item_reg.slot_index);

    assign out_valid  = out_valid_reg;
    assign out_phys   = out_phys_reg;
    assign out_status = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        bit_cnt_next    = bit_cnt_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_pend_next   = (state_reg == B_WALK);
        found_next      = found_reg;
        hit_base_next   = hit_base_reg;
        hit_len_next    = hit_len_reg;
        sum_next        = sum_reg;
        res_phys_next   = res_phys_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_phys_next   = out_phys_reg;
        out_status_next = out_status_reg;
        q_ready         = 1'b0;

        // Last match wins: overwrite the hit on every matching slot.
        if (match)
        begin
            found_next    = 1'b1;
            hit_base_next = rd_slot_reg.base;
            hit_len_next  = rd_slot_reg.length;
        end

        unique case (state_reg)
            B_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    item_next    = q_data;
                    quo_next     = q_data.logical_address;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = q_data.is_write ? B_WRITE : B_DIV;
                end
            end
            B_WRITE:
            begin
                res_status_next = ST_OK;
                res_phys_next   = '0;
                state_next      = B_DONE;
            end
            B_DIV:
            begin
                // Restoring step; a zero divisor yields all ones and the dividend.
                rem_next     = diff[33] ? rem_shift[31:0] : diff[31:0];
                quo_next     = {quo_reg[30:0], ~diff[33]};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    rd_idx_next = '0;
                    found_next  = 1'b0;
                    state_next  = B_WALK;
                end
            end
            B_WALK:
            begin
                if (rd_idx_reg == IDX_W'(SEGMENT_SLOTS - 1))
                begin
                    state_next = B_TAIL;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            B_TAIL:
            begin
                sum_next   = {1'b0, rem_reg} + {17'd0, item_reg.access_size};
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                res_phys_next = '0;
                if (!found_reg)
                begin
                    res_status_next = ST_NOSEG;
                end
                else if (sum_reg > {1'b0, hit_len_reg})
                begin
                    res_status_next = ST_BOUNDS;
                end
                else
                begin
                    res_status_next = ST_OK;
                    res_phys_next   = {1'b0, rem_reg} + {1'b0, hit_base_reg};
                end
                state_next = B_DONE;
            end
            B_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_phys_next   = res_phys_reg;
                    out_status_next = res_status_reg;
                    state_next      = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            bit_cnt_reg    <= '0;
            rd_idx_reg     <= '0;
            cmp_pend_reg   <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_pend_reg  <= cmp_pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                slot_valid_reg[wr_addr] <= item_reg.slot_enable;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        hit_base_reg   <= hit_base_next;
        hit_len_reg    <= hit_len_next;
        sum_reg        <= sum_next;
        res_phys_reg   <= res_phys_next;
        res_status_reg <= res_status_next;
        out_phys_reg   <= out_phys_next;
        out_status_reg <= out_status_next;
    end

    // Slot table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= '{segment_id: item_reg.segment_id,
                                   base:       item_reg.segment_base,
                                   length:     item_reg.segment_length};
        end
        rd_slot_reg  <= slot_mem[rd_idx_reg];
        rd_valid_reg <= slot_valid_reg[rd_idx_reg];
    end

endmodule
